[hdl/lcdnib_pkg.sv]
// ----------------------------------------------------------------------------
// lcdnib_pkg
// Shared types, constants and the control store of the 4-bit LCD nibble
// sequencer.
// ----------------------------------------------------------------------------
package lcdnib_pkg;

  localparam int unsigned COLUMNS    = 16;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned BCD_W      = 4 * MAX_DIGITS;
  localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
  localparam int unsigned PC_W       = 5;

  localparam logic [7:0] COL_LIMIT  = 8'(COLUMNS);
  localparam logic [7:0] ASCII_ZERO = 8'd48;

  typedef enum logic [2:0] {
    KIND_INIT   = 3'd0,
    KIND_CMD    = 3'd1,
    KIND_CHAR   = 3'd2,
    KIND_CURSOR = 3'd3,
    KIND_INT    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_FSET  = 3'd0,
    REG_DISP  = 3'd1,
    REG_CLR   = 3'd2,
    REG_ENTRY = 3'd3,
    REG_LINE0 = 3'd4,
    REG_LINE1 = 3'd5
  } reg_idx_t;

  localparam logic [7:0] RST_FSET  = 8'd40;
  localparam logic [7:0] RST_DISP  = 8'd12;
  localparam logic [7:0] RST_CLR   = 8'd1;
  localparam logic [7:0] RST_ENTRY = 8'd6;
  localparam logic [7:0] RST_LINE0 = 8'd128;
  localparam logic [7:0] RST_LINE1 = 8'd192;

  // byte source for a strobe
  typedef enum logic [2:0] {
    SRC_FSET,
    SRC_DISP,
    SRC_CLR,
    SRC_ENTRY,
    SRC_BYTE,
    SRC_DIGIT
  } src_sel_t;

  // datapath operation of a step
  typedef enum logic [1:0] {
    DP_NONE,
    DP_DABBLE,
    DP_SKIP,
    DP_DIGIT
  } dp_op_t;

  // jump condition of a step
  typedef enum logic [1:0] {
    JC_NEVER,
    JC_BITS,
    JC_LEADZ,
    JC_MORE
  } jcond_t;

  typedef struct packed {
    logic            emit;
    logic            hi;
    logic            rs;
    src_sel_t        src;
    dp_op_t          dp;
    jcond_t          cond;
    logic            fin;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_INIT  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_CMD   = PC_W'(9);
  localparam logic [PC_W-1:0] PC_CHAR  = PC_W'(11);
  localparam logic [PC_W-1:0] PC_INT   = PC_W'(13);
  localparam logic [PC_W-1:0] PC_SKIP  = PC_W'(14);
  localparam logic [PC_W-1:0] PC_DIGIT = PC_W'(15);
  localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(17);

  function automatic ucode_t mk_word(input logic emit, input logic hi, input logic rs,
                                     input src_sel_t src, input dp_op_t dp,
                                     input jcond_t cond, input logic fin,
                                     input logic [PC_W-1:0] target);
    ucode_t w;
    w.emit   = emit;
    w.hi     = hi;
    w.rs     = rs;
    w.src    = src;
    w.dp     = dp;
    w.cond   = cond;
    w.fin    = fin;
    w.target = target;
    return w;
  endfunction

  // Control store. A step that ends its request has fin set; it ends only
  // when its jump is not taken.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = mk_word(1'b0, 1'b0, 1'b0, SRC_BYTE, DP_NONE, JC_NEVER, 1'b1, PC_IDLE);
    case (pc)
      // init: lone function-set high nibble, then four full commands
      5'd0:  w = mk_word(1'b1, 1'b1, 1'b0, SRC_FSET,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd1:  w = mk_word(1'b1, 1'b1, 1'b0, SRC_FSET,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd2:  w = mk_word(1'b1, 1'b0, 1'b0, SRC_FSET,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd3:  w = mk_word(1'b1, 1'b1, 1'b0, SRC_DISP,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd4:  w = mk_word(1'b1, 1'b0, 1'b0, SRC_DISP,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd5:  w = mk_word(1'b1, 1'b1, 1'b0, SRC_CLR,   DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd6:  w = mk_word(1'b1, 1'b0, 1'b0, SRC_CLR,   DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd7:  w = mk_word(1'b1, 1'b1, 1'b0, SRC_ENTRY, DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd8:  w = mk_word(1'b1, 1'b0, 1'b0, SRC_ENTRY, DP_NONE, JC_NEVER, 1'b1, PC_IDLE);
      // command byte (also cursor address)
      5'd9:  w = mk_word(1'b1, 1'b1, 1'b0, SRC_BYTE,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd10: w = mk_word(1'b1, 1'b0, 1'b0, SRC_BYTE,  DP_NONE, JC_NEVER, 1'b1, PC_IDLE);
      // character byte
      5'd11: w = mk_word(1'b1, 1'b1, 1'b1, SRC_BYTE,  DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd12: w = mk_word(1'b1, 1'b0, 1'b1, SRC_BYTE,  DP_NONE, JC_NEVER, 1'b1, PC_IDLE);
      // integer: binary to BCD, drop leading zeros, print digits
      5'd13: w = mk_word(1'b0, 1'b0, 1'b1, SRC_DIGIT, DP_DABBLE, JC_BITS, 1'b0, PC_INT);
      5'd14: w = mk_word(1'b0, 1'b0, 1'b1, SRC_DIGIT, DP_SKIP, JC_LEADZ, 1'b0, PC_SKIP);
      5'd15: w = mk_word(1'b1, 1'b1, 1'b1, SRC_DIGIT, DP_NONE, JC_NEVER, 1'b0, PC_IDLE);
      5'd16: w = mk_word(1'b1, 1'b0, 1'b1, SRC_DIGIT, DP_DIGIT, JC_MORE, 1'b1, PC_DIGIT);
      default: ;
    endcase
    return w;
  endfunction

  // add 3 to every BCD digit above 4 ahead of the shift
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (b[4*i +: 4] > 4'd4) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

[hdl/lcd_4bit_nibble_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// lcd_4bit_nibble_sequencer_unit
// Turns LCD requests into RS/nibble strobes for a 4-bit character bus,
// run by a small microprogram over a byte mux and a BCD converter.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Beat taken when
// request   start, busy, in_kind/value/line/column  start && !busy
// result    out_strobe, out_reg_select/nibble/last  out_strobe (one cycle)
// config    cfg_valid, cfg_ready, cfg_index/data    cfg_valid && cfg_ready
//
// One microcode step per cycle; each strobe step gives one result beat in the
// cycle after. An integer runs one conversion step per input bit, one step
// per dropped leading zero plus one, and a high- and a low-nibble step per
// digit.
// Requests that send nothing keep busy high for one cycle.
// Reset is synchronous and restores the register defaults; results cannot
// be stalled, and cfg_ready is always high.
// ----------------------------------------------------------------------------
module lcd_4bit_nibble_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_kind,
  input  logic [lcdnib_pkg::VALUE_W-1:0]    in_value,
  input  logic [1:0]                        in_line,
  input  logic [7:0]                        in_column,
  output logic                              out_strobe,
  output logic                              out_reg_select,
  output logic [3:0]                        out_nibble,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [7:0]                        cfg_data
);
  import lcdnib_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic                 strobe_r, strobe_nxt;
  logic                 rs_r, rs_nxt;
  logic [3:0]           nib_r, nib_nxt;
  logic                 last_r, last_nxt;

  logic [7:0]           fset_r, disp_r, clr_r, entry_r, line0_r, line1_r;

  logic [7:0]           byte_r, byte_nxt;
  logic [VALUE_W-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [BIT_CNT_W-1:0] bitcnt_r, bitcnt_nxt;
  logic [DIG_CNT_W-1:0] digcnt_r, digcnt_nxt;

  ucode_t               cw;
  logic                 accept;
  logic                 take;
  logic                 more_digits;
  logic                 lead_zero;
  logic                 cursor_ok;
  logic [3:0]           top_digit;
  logic [7:0]           src_byte;
  logic [PC_W-1:0]      entry_pc;
  logic [BCD_W-1:0]     bcd_adj;

  assign accept      = start && !busy_r;
  assign cw          = ucode_rom(pc_r);
  assign top_digit   = bcd_r[BCD_W-1 -: 4];
  assign more_digits = digcnt_r > DIG_CNT_W'(1);
  assign lead_zero   = (top_digit == 4'd0) && more_digits;
  assign cursor_ok   = !in_line[1] && (in_column < COL_LIMIT);
  assign bcd_adj     = bcd_adjust(bcd_r);

  always_comb begin
    unique case (cw.cond)
      JC_NEVER: take = 1'b0;
      JC_BITS:  take = bitcnt_r != '0;
      JC_LEADZ: take = lead_zero;
      JC_MORE:  take = more_digits;
    endcase
  end

  always_comb begin
    unique case (cw.src)
      SRC_FSET:  src_byte = fset_r;
      SRC_DISP:  src_byte = disp_r;
      SRC_CLR:   src_byte = clr_r;
      SRC_ENTRY: src_byte = entry_r;
      SRC_BYTE:  src_byte = byte_r;
      SRC_DIGIT: src_byte = ASCII_ZERO + {4'd0, top_digit};
      default:   src_byte = byte_r;
    endcase
  end

  always_comb begin
    unique case (in_kind)
      KIND_INIT:   entry_pc = PC_INIT;
      KIND_CMD:    entry_pc = PC_CMD;
      KIND_CHAR:   entry_pc = PC_CHAR;
      KIND_CURSOR: entry_pc = cursor_ok ? PC_CMD : PC_IDLE;
      KIND_INT:    entry_pc = PC_INT;
      default:     entry_pc = PC_IDLE;
    endcase
  end

  always_comb begin
    busy_nxt   = busy_r;
    pc_nxt     = pc_r;
    strobe_nxt = 1'b0;
    rs_nxt     = cw.rs;
    nib_nxt    = cw.hi ? src_byte[7:4] : src_byte[3:0];
    last_nxt   = cw.fin && !take;
    byte_nxt   = byte_r;
    bin_nxt    = bin_r;
    bcd_nxt    = bcd_r;
    bitcnt_nxt = bitcnt_r;
    digcnt_nxt = digcnt_r;

    if (accept) begin
      busy_nxt   = 1'b1;
      pc_nxt     = entry_pc;
      byte_nxt   = (in_kind == KIND_CURSOR)
                   ? in_column + (in_line[0] ? line1_r : line0_r)
                   : in_value[7:0];
      bin_nxt    = in_value;
      bcd_nxt    = '0;
      bitcnt_nxt = BIT_CNT_W'(VALUE_W - 1);
      digcnt_nxt = DIG_CNT_W'(MAX_DIGITS);
    end else if (busy_r) begin
      strobe_nxt = cw.emit;
      pc_nxt     = take ? cw.target : pc_r + PC_W'(1);
      if (cw.fin && !take) begin
        busy_nxt = 1'b0;
      end
      unique case (cw.dp)
        DP_NONE: ;
        DP_DABBLE: begin
          bcd_nxt    = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
          bin_nxt    = {bin_r[VALUE_W-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r - BIT_CNT_W'(1);
        end
        DP_SKIP: begin
          // drop a leading zero digit, keep at least one
          if (lead_zero) begin
            bcd_nxt    = {bcd_r[BCD_W-5:0], 4'd0};
            digcnt_nxt = digcnt_r - DIG_CNT_W'(1);
          end
        end
        DP_DIGIT: begin
          bcd_nxt    = {bcd_r[BCD_W-5:0], 4'd0};
          digcnt_nxt = digcnt_r - DIG_CNT_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      pc_r     <= PC_IDLE;
      strobe_r <= 1'b0;
      fset_r   <= RST_FSET;
      disp_r   <= RST_DISP;
      clr_r    <= RST_CLR;
      entry_r  <= RST_ENTRY;
      line0_r  <= RST_LINE0;
      line1_r  <= RST_LINE1;
    end else begin
      busy_r   <= busy_nxt;
      pc_r     <= pc_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FSET:  fset_r  <= cfg_data;
          REG_DISP:  disp_r  <= cfg_data;
          REG_CLR:   clr_r   <= cfg_data;
          REG_ENTRY: entry_r <= cfg_data;
          REG_LINE0: line0_r <= cfg_data;
          REG_LINE1: line1_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rs_r     <= rs_nxt;
    nib_r    <= nib_nxt;
    last_r   <= last_nxt;
    byte_r   <= byte_nxt;
    bin_r    <= bin_nxt;
    bcd_r    <= bcd_nxt;
    bitcnt_r <= bitcnt_nxt;
    digcnt_r <= digcnt_nxt;
  end

  assign busy           = busy_r;
  assign out_strobe     = strobe_r;
  assign out_reg_select = rs_r;
  assign out_nibble     = nib_r;
  assign out_last       = last_r;
  assign cfg_ready      = 1'b1;

endmodule

[hdl/lcdnib_chk.sv]
// ----------------------------------------------------------------------------
// lcdnib_chk
// Port-level checks of the LCD nibble sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lcdnib_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_last
);

  // a taken request always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a taken request");

  // every beat comes from a step run while busy
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_strobe)
    else $error("beat without a preceding busy cycle");

  // final beat arrives after the sequencer has released
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("busy still high on final beat");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("non-final beat while idle");

endmodule

bind lcd_4bit_nibble_sequencer_unit lcdnib_chk u_lcdnib_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_last   (out_last)
);
